### rtl/core/image_convolution_clamped_edge_core_defines.svh
// Assertion macros shared by the checker.
`ifndef IMAGE_CONVOLUTION_CLAMPED_EDGE_CORE_DEFINES_SVH
`define IMAGE_CONVOLUTION_CLAMPED_EDGE_CORE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define ICE_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("check failed");

// Next-cycle implication checked outside reset.
`define ICE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("check failed");

`endif

### rtl/core/ice_pkg.sv
`timescale 1ns / 1ps
package ice_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_COEF = 2'd0,
    CMD_LOAD_PIXEL = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KERNEL_ROWS = 3'd2;
  localparam logic [2:0] REG_KERNEL_COLS = 3'd3;
  localparam logic [2:0] REG_COLOR_MODE = 3'd4;

  // Accumulator ceiling, 255.0 in Q8.8
  localparam logic [15:0] ACC_MAX = 16'hFF00;

endpackage

### rtl/core/image_convolution_clamped_edge_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_command, in_row, in_column,
//         |           | in_coefficient, in_red, in_green, in_blue
// out     | output    | out_valid, out_ready, out_red, out_green, out_blue
// cfg     | input     | cfg_we, cfg_index, cfg_data
// A compute walks kernel_rows*kernel_cols taps, one image-store and
// coefficient-store read per tap, then passes through the read latency, the
// product register and the accumulate register; input reopens when the result
// is registered. A waiting result does not block input; only a finished walk
// waits for the result register to free up. Reset is synchronous, active low,
// and clears control state and sets the configuration registers to defaults.
module image_convolution_clamped_edge_core
  import ice_pkg::*;
#(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_KERNEL = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_row,
  input  logic [5:0]  in_column,
  input  logic signed [15:0] in_coefficient,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int KW = $clog2(MAX_KERNEL + 1);
  localparam int KD = MAX_KERNEL * MAX_KERNEL;
  localparam int KAW = (KD > 1) ? $clog2(KD) : 1;
  localparam int ID = MAX_WIDTH * MAX_HEIGHT;
  localparam int IAW = (ID > 1) ? $clog2(ID) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_FINISH} state_t;

  // Configuration registers
  logic [6:0] width_r, height_r;
  logic [2:0] krows_r, kcols_r;
  logic       color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 7'd64;
      height_r <= 7'd64;
      krows_r <= 3'd3;
      kcols_r <= 3'd3;
      color_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: width_r <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        REG_KERNEL_ROWS: krows_r <= cfg_data[2:0];
        REG_KERNEL_COLS: kcols_r <= cfg_data[2:0];
        REG_COLOR_MODE: color_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturated geometry
  logic [10:0] w_sat, h_sat;
  logic [KW-1:0] kr_sat, kc_sat;
  always_comb begin
    w_sat = (width_r == 7'd0) ? 11'd1 :
            ({4'd0, width_r} > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : {4'd0, width_r};
    h_sat = (height_r == 7'd0) ? 11'd1 :
            ({4'd0, height_r} > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : {4'd0, height_r};
    kr_sat = (krows_r == 3'd0) ? KW'(1) :
             (32'(krows_r) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(krows_r);
    kc_sat = (kcols_r == 3'd0) ? KW'(1) :
             (32'(kcols_r) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kcols_r);
  end

  // Memories
  logic [23:0] img_mem [ID];
  logic [15:0] coef_mem [KD];
  logic [23:0] px_rd;
  logic [15:0] cf_rd;
  logic [IAW-1:0] img_raddr;
  logic [KAW-1:0] coef_raddr;

  logic [1:0] state_r;
  state_t     st;
  assign st = state_t'(state_r);
  logic       acc_ok;
  logic       in_fire;
  assign in_fire = in_valid && in_ready;

  wire pix_ok = (32'(in_row) < MAX_HEIGHT) && (32'(in_column) < MAX_WIDTH);
  wire coef_ok = (32'(in_row) < MAX_KERNEL) && (32'(in_column) < MAX_KERNEL);

  always_ff @(posedge clk) begin
    if (in_fire && cmd_t'(in_command) == CMD_LOAD_PIXEL && pix_ok)
      img_mem[IAW'(32'(in_row) * MAX_WIDTH + 32'(in_column))] <= {in_blue, in_green, in_red};
    if (in_fire && cmd_t'(in_command) == CMD_LOAD_COEF && coef_ok)
      coef_mem[KAW'(32'(in_row) * MAX_KERNEL + 32'(in_column))] <= in_coefficient;
    px_rd <= img_mem[img_raddr];
    cf_rd <= coef_mem[coef_raddr];
  end

  // Tap walk
  logic [5:0] row_r, col_r;
  logic [KW-1:0] ik_r, jk_r;
  logic       rd_v_r;
  logic signed [12:0] tr, tc;
  logic [YW-1:0] tr_c;
  logic [XW-1:0] tc_c;

  always_comb begin
    tr = 13'(row_r) - 13'(kr_sat >> 1) + 13'(ik_r);
    tc = 13'(col_r) - 13'(kc_sat >> 1) + 13'(jk_r);
    tr_c = (tr < 0) ? '0 : (tr >= 13'(h_sat)) ? YW'(h_sat - 11'd1) : YW'(tr);
    tc_c = (tc < 0) ? '0 : (tc >= 13'(w_sat)) ? XW'(w_sat - 11'd1) : XW'(tc);
    img_raddr = IAW'(32'(tr_c) * MAX_WIDTH + 32'(tc_c));
    coef_raddr = KAW'(32'(ik_r) * MAX_KERNEL + 32'(jk_r));
  end

  wire last_tap = (ik_r == kr_sat - KW'(1)) && (jk_r == kc_sat - KW'(1));

  // Multiply stage registered, then accumulate
  logic signed [24:0] prod_r [3];
  logic       prod_v_r;
  logic [15:0] acc_r [3];
  logic [7:0] res [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [16:0] rr;
      rr = {1'b0, acc_r[c]} + 17'd128;
      res[c] = (c == 0 || color_r) ? rr[15:8] : 8'd0;
    end
  end

  assign acc_ok = !out_valid || out_ready;
  assign in_ready = (st == ST_IDLE);

  // Finished walk moves into the result register once it is free
  wire fin_go = (st == ST_FINISH) && !prod_v_r && !rd_v_r && acc_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid <= 1'b0;
      rd_v_r <= 1'b0;
      prod_v_r <= 1'b0;
      ik_r <= '0;
      jk_r <= '0;
    end else begin
      if (fin_go) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      rd_v_r <= 1'b0;
      prod_v_r <= rd_v_r;
      for (int c = 0; c < 3; c++)
        prod_r[c] <= $signed({17'd0, px_rd[8*c +: 8]}) * $signed(cf_rd);
      if (prod_v_r) begin
        for (int c = 0; c < 3; c++) begin
          logic signed [25:0] s;
          s = $signed({10'd0, acc_r[c][15:8], 8'd0}) + 26'(prod_r[c]);
          acc_r[c] <= (s < 0) ? 16'd0 : (s > $signed({10'd0, ACC_MAX})) ? ACC_MAX : s[15:0];
        end
      end
      unique case (st)
        ST_IDLE: begin
          if (in_fire && cmd_t'(in_command) == CMD_COMPUTE) begin
            row_r <= in_row;
            col_r <= in_column;
            ik_r <= '0;
            jk_r <= '0;
            for (int c = 0; c < 3; c++) acc_r[c] <= '0;
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          rd_v_r <= 1'b1;
          if (last_tap) state_r <= ST_DRAIN;
          else if (jk_r == kc_sat - KW'(1)) begin
            jk_r <= '0;
            ik_r <= ik_r + KW'(1);
          end else jk_r <= jk_r + KW'(1);
        end
        ST_DRAIN: state_r <= ST_FINISH;
        ST_FINISH: begin
          if (fin_go) begin
            out_red <= res[0];
            out_green <= res[1];
            out_blue <= res[2];
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/ice_checker.sv
`timescale 1ns / 1ps
`include "image_convolution_clamped_edge_core_defines.svh"
module ice_checker
  import ice_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // A stalled result stays valid and keeps its red channel
  `ICE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_red))
  // A compute transfer closes input
  `ICE_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready && in_command == CMD_COMPUTE, !in_ready)
  // Loads never raise a result
  `ICE_ASSERT_NEXT(a_load_quiet, clk, rst_n,
    in_valid && in_ready && in_command != CMD_COMPUTE && !out_valid, !out_valid)
  // A new result only follows a busy cycle
  `ICE_ASSERT_IMPL(a_rise_after_walk, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind image_convolution_clamped_edge_core ice_checker u_ice_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_command(in_command), .out_valid(out_valid), .out_ready(out_ready),
  .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
);
